>>> hdl/opn_pkg.sv
// Shared types and constants for the octave Perlin noise block.
`timescale 1ns / 1ps
`default_nettype none

package opn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_FRAC  = 14;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int TBL_AW    = 8;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int OCT_DEPTH = 8;
    localparam int AMP_W     = 17;
    localparam int PERS_W    = 16;
    localparam int OCT_CNT_W = 4;
    localparam int TERM_W    = 20;
    localparam int SUM_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [AMP_W-1:0]        AMP_ONE = AMP_W'(ONE_Q);
    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(ONE_Q);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd1;

    // gradient direction selected by the two low hash bits
    localparam logic [1:0] G_XPY  = 2'd0;
    localparam logic [1:0] G_NXPY = 2'd1;
    localparam logic [1:0] G_NXNY = 2'd2;
    localparam logic [1:0] G_XNY  = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } item_t;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic               was_clamped;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/opn_octave.sv
// One noise octave: table copies, fade, gradients, lerps and amplitude weight, 8 stages.
`timescale 1ns / 1ps
`default_nettype none

module opn_octave #(
    parameter int SHIFT = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_vld,
    input  wire opn_pkg::item_t                    in_item,
    input  wire logic [opn_pkg::AMP_W-1:0]         amp,
    output logic signed [opn_pkg::TERM_W-1:0]      term
);

    localparam logic [20:0] Q_BASE = 21'(10 * opn_pkg::ONE_Q);

    function automatic logic signed [18:0] grad(input logic [1:0] h,
                                                input logic signed [17:0] gx,
                                                input logic signed [17:0] gy);
        logic signed [18:0] xe;
        logic signed [18:0] ye;
        xe = 19'(gx);
        ye = 19'(gy);
        unique case (h)
            opn_pkg::G_XPY:  grad = xe + ye;
            opn_pkg::G_NXPY: grad = ye - xe;
            opn_pkg::G_NXNY: grad = -xe - ye;
            opn_pkg::G_XNY:  grad = xe - ye;
            default:         grad = xe + ye;
        endcase
    endfunction

    // stage 1: cell, fraction, first hash
    logic [23:0] px;
    logic [23:0] py;
    logic [7:0]  xi;
    logic        ld0;
    logic [31:0] sqx_next;
    logic [31:0] sqy_next;

    logic [7:0]  mem_a_reg [opn_pkg::TBL_DEPTH];
    logic [7:0]  ha0_reg;
    logic [7:0]  ha1_reg;
    logic        s1_ld_reg;
    logic [7:0]  s1_idx_reg;
    logic [7:0]  s1_val_reg;
    logic [15:0] fx1_reg;
    logic [15:0] fy1_reg;
    logic [7:0]  yi1_reg;
    logic [31:0] sqx1_reg;
    logic [31:0] sqy1_reg;

    assign px       = in_item.pos_x[23:0] << SHIFT;
    assign py       = in_item.pos_y[23:0] << SHIFT;
    assign xi       = px[23:16];
    assign ld0      = in_vld && (in_item.cmd == opn_pkg::CMD_LOAD);
    assign sqx_next = px[15:0] * px[15:0];
    assign sqy_next = py[15:0] * py[15:0];

    always_ff @(posedge clk) begin
        if (ld0) begin
            mem_a_reg[in_item.table_index] <= in_item.table_value;
        end
        ha0_reg    <= mem_a_reg[xi];
        ha1_reg    <= mem_a_reg[xi + 8'd1];
        s1_idx_reg <= in_item.table_index;
        s1_val_reg <= in_item.table_value;
        fx1_reg    <= px[15:0];
        fy1_reg    <= py[15:0];
        yi1_reg    <= py[23:16];
        sqx1_reg   <= sqx_next;
        sqy1_reg   <= sqy_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_ld_reg <= 1'b0;
        end else begin
            s1_ld_reg <= ld0;
        end
    end

    // stage 2: corner hashes, t^3 product
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [15:0] t2x;
    logic [15:0] t2y;
    logic [31:0] cubx_next;
    logic [31:0] cuby_next;

    logic [7:0]  mem_b_reg [opn_pkg::TBL_DEPTH];
    logic [7:0]  mem_c_reg [opn_pkg::TBL_DEPTH];
    logic [7:0]  h00_reg;
    logic [7:0]  h01_reg;
    logic [7:0]  h10_reg;
    logic [7:0]  h11_reg;
    logic [15:0] fx2_reg;
    logic [15:0] fy2_reg;
    logic [15:0] t2x2_reg;
    logic [15:0] t2y2_reg;
    logic [31:0] cubx2_reg;
    logic [31:0] cuby2_reg;

    assign ca        = ha0_reg + yi1_reg;
    assign cb        = ha1_reg + yi1_reg;
    assign t2x       = sqx1_reg[31:16];
    assign t2y       = sqy1_reg[31:16];
    assign cubx_next = t2x * fx1_reg;
    assign cuby_next = t2y * fy1_reg;

    always_ff @(posedge clk) begin
        if (s1_ld_reg) begin
            mem_b_reg[s1_idx_reg] <= s1_val_reg;
            mem_c_reg[s1_idx_reg] <= s1_val_reg;
        end
        h00_reg   <= mem_b_reg[ca];
        h01_reg   <= mem_b_reg[ca + 8'd1];
        h10_reg   <= mem_c_reg[cb];
        h11_reg   <= mem_c_reg[cb + 8'd1];
        fx2_reg   <= fx1_reg;
        fy2_reg   <= fy1_reg;
        t2x2_reg  <= t2x;
        t2y2_reg  <= t2y;
        cubx2_reg <= cubx_next;
        cuby2_reg <= cuby_next;
    end

    // stage 3: fade product, gradients
    logic [20:0]        qx;
    logic [20:0]        qy;
    logic [36:0]        fadex_next;
    logic [36:0]        fadey_next;
    logic signed [17:0] sx;
    logic signed [17:0] sy;
    logic signed [17:0] sxm;
    logic signed [17:0] sym;

    logic [36:0]        fadex3_reg;
    logic [36:0]        fadey3_reg;
    logic signed [18:0] g00_reg;
    logic signed [18:0] g01_reg;
    logic signed [18:0] g10_reg;
    logic signed [18:0] g11_reg;

    // q = 6 t2 - 15 t + 10 stays in [0, 2^21), so the modular sum is exact
    assign qx  = Q_BASE + 21'(6 * t2x2_reg) - 21'(15 * fx2_reg);
    assign qy  = Q_BASE + 21'(6 * t2y2_reg) - 21'(15 * fy2_reg);
    assign fadex_next = cubx2_reg[31:16] * qx;
    assign fadey_next = cuby2_reg[31:16] * qy;
    assign sx  = {2'b00, fx2_reg};
    assign sy  = {2'b00, fy2_reg};
    assign sxm = {2'b11, fx2_reg};
    assign sym = {2'b11, fy2_reg};

    always_ff @(posedge clk) begin
        fadex3_reg <= fadex_next;
        fadey3_reg <= fadey_next;
        g00_reg    <= grad(h00_reg[1:0], sx, sy);
        g01_reg    <= grad(h01_reg[1:0], sx, sym);
        g10_reg    <= grad(h10_reg[1:0], sxm, sy);
        g11_reg    <= grad(h11_reg[1:0], sxm, sym);
    end

    // stage 4: lerp products along y
    logic [16:0]        u;
    logic [16:0]        v;
    logic signed [19:0] d0;
    logic signed [19:0] d1;
    logic signed [37:0] m0_next;
    logic signed [37:0] m1_next;

    logic signed [37:0] m0_reg;
    logic signed [37:0] m1_reg;
    logic signed [18:0] g00_4_reg;
    logic signed [18:0] g10_4_reg;
    logic [16:0]        u4_reg;

    assign u       = fadex3_reg[32:16];
    assign v       = fadey3_reg[32:16];
    assign d0      = 20'(g01_reg) - 20'(g00_reg);
    assign d1      = 20'(g11_reg) - 20'(g10_reg);
    assign m0_next = d0 * $signed({1'b0, v});
    assign m1_next = d1 * $signed({1'b0, v});

    always_ff @(posedge clk) begin
        m0_reg    <= m0_next;
        m1_reg    <= m1_next;
        g00_4_reg <= g00_reg;
        g10_4_reg <= g10_reg;
        u4_reg    <= u;
    end

    // stage 5: y lerp sums
    logic signed [21:0] l0_next;
    logic signed [21:0] l1_next;
    logic signed [18:0] l0_reg;
    logic signed [18:0] l1_reg;
    logic [16:0]        u5_reg;

    assign l0_next = 22'(g00_4_reg) + 22'(m0_reg >>> 16);
    assign l1_next = 22'(g10_4_reg) + 22'(m1_reg >>> 16);

    always_ff @(posedge clk) begin
        l0_reg <= l0_next[18:0];
        l1_reg <= l1_next[18:0];
        u5_reg <= u4_reg;
    end

    // stage 6: x lerp product
    logic signed [19:0] d2;
    logic signed [37:0] m2_next;
    logic signed [37:0] m2_reg;
    logic signed [18:0] l0_6_reg;

    assign d2      = 20'(l1_reg) - 20'(l0_reg);
    assign m2_next = d2 * $signed({1'b0, u5_reg});

    always_ff @(posedge clk) begin
        m2_reg   <= m2_next;
        l0_6_reg <= l0_reg;
    end

    // stage 7: octave noise value
    logic signed [21:0] nv_next;
    logic signed [18:0] nv_reg;

    assign nv_next = 22'(l0_6_reg) + 22'(m2_reg >>> 16);

    always_ff @(posedge clk) begin
        nv_reg <= nv_next[18:0];
    end

    // stage 8: amplitude weight
    logic signed [36:0] w_next;
    logic signed [36:0] w_reg;

    assign w_next = nv_reg * $signed({1'b0, amp});

    always_ff @(posedge clk) begin
        w_reg <= w_next;
    end

    assign term = opn_pkg::TERM_W'(w_reg >>> 16);

endmodule

`default_nettype wire

>>> hdl/octave_perlin_noise_2d.sv
// Top level: fixed-point fBm Perlin noise, octaves computed side by side.
// Evaluate items pass the input register, the octave stages, the adder tree and the output register before done.
// Throughput: one item per cycle while busy is low, set by the per-octave pipelines and their table copies.
// Loads write each octave's copies as they pass its first two stages; they give no result.
// busy is high after reset and after a persistence write, until the settle counter has counted down to zero.
// rst_n resets configuration and valid state; data and tables are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module octave_perlin_noise_2d #(
    parameter int MAX_OCTAVES = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire opn_pkg::item_t                      item,
    output logic                                     done,
    output opn_pkg::result_t                         result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [opn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [opn_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int LEVELS   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
    localparam int NPAD     = 1 << LEVELS;
    localparam int PIPE     = opn_pkg::OCT_DEPTH + LEVELS;
    localparam int SETTLE_W = $clog2(MAX_OCTAVES + 1);

    // configuration
    logic [opn_pkg::OCT_CNT_W-1:0] octave_count_reg;
    logic [opn_pkg::PERS_W-1:0]    persist_reg;
    logic [SETTLE_W-1:0]           settle_reg;
    logic [SETTLE_W-1:0]           settle_next;
    logic                          cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (settle_reg != '0);

    always_comb begin
        settle_next = settle_reg;
        if (cfg_wr && (cfg_index == opn_pkg::CFG_PERSIST)) begin
            settle_next = SETTLE_W'(MAX_OCTAVES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            octave_count_reg <= opn_pkg::OCT_CNT_W'(4);
            persist_reg      <= opn_pkg::PERS_W'(32768);
            settle_reg       <= SETTLE_W'(MAX_OCTAVES);
        end else begin
            settle_reg <= settle_next;
            if (cfg_wr && (cfg_index == opn_pkg::CFG_OCTAVES)) begin
                octave_count_reg <= cfg_data[opn_pkg::OCT_CNT_W-1:0];
            end
            if (cfg_wr && (cfg_index == opn_pkg::CFG_PERSIST)) begin
                persist_reg <= cfg_data[opn_pkg::PERS_W-1:0];
            end
        end
    end

    // amplitude chain, one multiply per octave after the first
    logic [opn_pkg::AMP_W-1:0] amp [MAX_OCTAVES];

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
        if (i == 0) begin : g_first
            assign amp[i] = opn_pkg::AMP_ONE;
        end else begin : g_next
            logic [opn_pkg::AMP_W+opn_pkg::PERS_W-1:0] prod;
            logic [opn_pkg::AMP_W-1:0]                 amp_next;
            logic [opn_pkg::AMP_W-1:0]                 amp_reg;
            assign prod     = amp[i-1] * persist_reg;
            assign amp_next = prod[opn_pkg::AMP_W+opn_pkg::PERS_W-1:opn_pkg::PERS_W];
            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    amp_reg <= '0;
                end else begin
                    amp_reg <= amp_next;
                end
            end
            assign amp[i] = amp_reg;
        end
    end

    // input stage
    logic           accept;
    logic           s0_vld_reg;
    opn_pkg::item_t s0_item_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk) begin
        if (accept) begin
            s0_item_reg <= item;
        end
    end

    // evaluate valid bits alongside the octave pipelines and the sum tree
    logic [PIPE-1:0] vld_pipe_reg;
    logic [PIPE-1:0] vld_pipe_next;

    assign vld_pipe_next = {vld_pipe_reg[PIPE-2:0],
                            s0_vld_reg && (s0_item_reg.cmd == opn_pkg::CMD_EVAL)};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_vld_reg   <= 1'b0;
            vld_pipe_reg <= '0;
        end else begin
            s0_vld_reg   <= accept;
            vld_pipe_reg <= vld_pipe_next;
        end
    end

    // octaves
    logic signed [opn_pkg::TERM_W-1:0] term [MAX_OCTAVES];

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
        opn_octave #(
            .SHIFT (i)
        ) u_oct (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (s0_vld_reg),
            .in_item (s0_item_reg),
            .amp     (amp[i]),
            .term    (term[i])
        );
    end

    // registered adder tree
    logic signed [opn_pkg::SUM_W-1:0] sum_node [LEVELS+1][NPAD];

    for (genvar j = 0; j < NPAD; j++) begin : g_leaf
        if (j < MAX_OCTAVES) begin : g_used
            assign sum_node[0][j] = (opn_pkg::OCT_CNT_W'(j) < octave_count_reg) ?
                                    opn_pkg::SUM_W'(term[j]) : '0;
        end else begin : g_pad
            assign sum_node[0][j] = '0;
        end
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        for (genvar j = 0; j < NPAD; j++) begin : g_node
            if (j < (NPAD >> l)) begin : g_add
                logic signed [opn_pkg::SUM_W-1:0] node_reg;
                always_ff @(posedge clk) begin
                    node_reg <= sum_node[l-1][2*j] + sum_node[l-1][2*j+1];
                end
                assign sum_node[l][j] = node_reg;
            end else begin : g_zero
                assign sum_node[l][j] = '0;
            end
        end
    end

    // clamp and output format
    logic signed [opn_pkg::SUM_W-1:0] root;
    logic signed [opn_pkg::SUM_W-1:0] clamp_val;
    logic                             clamp_flag;
    opn_pkg::result_t                 result_next;
    opn_pkg::result_t                 result_reg;
    logic                             done_reg;

    assign root = sum_node[LEVELS][0];

    always_comb begin
        priority if (root > opn_pkg::SUM_ONE) begin
            clamp_val  = opn_pkg::SUM_ONE;
            clamp_flag = 1'b1;
        end else if (root < -opn_pkg::SUM_ONE) begin
            clamp_val  = -opn_pkg::SUM_ONE;
            clamp_flag = 1'b1;
        end else begin
            clamp_val  = root;
            clamp_flag = 1'b0;
        end
        result_next.noise_value = 16'(clamp_val >>> (opn_pkg::FRAC_BITS - opn_pkg::OUT_FRAC));
        result_next.was_clamped = clamp_flag;
    end

    always_ff @(posedge clk) begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= vld_pipe_reg[PIPE-1];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> hdl/opn_checker.sv
// Port-level checks for the octave Perlin noise block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module opn_checker #(
    parameter int MAX_OCTAVES = 8
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire opn_pkg::item_t                item,
    input wire logic                          done,
    input wire opn_pkg::result_t              result,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [opn_pkg::CFG_IDX_W-1:0] cfg_index
);

    localparam int LEVELS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
    localparam int LAT    = opn_pkg::OCT_DEPTH + 2 + LEVELS;

    logic eval_take;
    assign eval_take = start && !busy && (item.cmd == opn_pkg::CMD_EVAL);

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.noise_value <= 16'sd16384 && result.noise_value >= -16'sd16384))
        else $error("noise value out of range");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.was_clamped) |->
            (result.noise_value == 16'sd16384 || result.noise_value == -16'sd16384))
        else $error("clamped item not at full scale");

    a_settle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == opn_pkg::CFG_PERSIST) |=> busy)
        else $error("persistence write did not hold off items");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        eval_take |-> ##LAT done)
        else $error("evaluate item lost");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(eval_take, LAT))
        else $error("result without evaluate item");

endmodule

bind octave_perlin_noise_2d opn_checker #(
    .MAX_OCTAVES (MAX_OCTAVES)
) u_opn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

`default_nettype wire
